/* design/box_table_collision_and_nearest_macros.svh */
// Assertion macros shared by the box table modules.
`ifndef BOX_TABLE_COLLISION_AND_NEAREST_MACROS_SVH
`define BOX_TABLE_COLLISION_AND_NEAREST_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BTCN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BTCN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/btcn_pkg.sv */
// Types, constants and codes shared by the box table modules.
`timescale 1ns / 1ps

package btcn_pkg;

   // Default table depth.
   localparam int BTCN_MAX_BOXES = 64;

   // Room geometry in Q8.8.
   localparam int Q_ONE     = 256;
   localparam int WALL      = 10 * Q_ONE;
   localparam int DOOR_HALF = 2 * Q_ONE;
   localparam int DOOR_TOP  = 8 * Q_ONE;

   // Datapath widths: box end, doubled center offset, square, sum of squares.
   localparam int END_W  = 17;
   localparam int D_W    = 19;
   localparam int SQ_W   = 35;
   localparam int DIST_W = 37;

   // Item kinds.
   typedef enum logic [1:0] {
      MODE_ADD  = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_NEAR = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] point_a_x;
      logic signed [15:0] point_a_y;
      logic signed [15:0] point_a_z;
      logic signed [15:0] point_b_x;
      logic signed [15:0] point_b_y;
      logic signed [15:0] point_b_z;
   } req_type;

   typedef struct packed {
      logic               move_allowed;
      logic               table_full;
      logic               box_found;
      logic [5:0]         nearest_index;
      logic signed [15:0] nearest_corner_x;
      logic signed [15:0] nearest_corner_y;
      logic signed [15:0] nearest_corner_z;
      logic signed [15:0] nearest_size_x;
      logic signed [15:0] nearest_size_y;
      logic signed [15:0] nearest_size_z;
   } rsp_type;

   // One stored box.
   typedef struct packed {
      logic signed [15:0] corner_x;
      logic signed [15:0] corner_y;
      logic signed [15:0] corner_z;
      logic signed [15:0] size_x;
      logic signed [15:0] size_y;
      logic signed [15:0] size_z;
   } box_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic wr_en;
      logic rd_en;
      logic respond;
      logic refused;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pipe_busy;
   } dp_status_type;

endpackage

/* design/box_table_collision_and_nearest.sv */
// Top level of the box table with move check and nearest-box search.
//
//   channel  ports                      handshake
//   request  start, busy, req_data      taken when start is high and busy is low
//   result   rsp_strobe, rsp_data       one cycle per item, receiver cannot stall
//
// An add goes through ST_WRITE and ST_FINISH to the result strobe, a refused
// add through ST_FINISH only; a move check or nearest query visits ST_SCAN
// once per stored box, then ST_WAIT and ST_FINISH (no ST_SCAN if empty).
// The scan reads one stored box per cycle through the single memory read port
// and drains a four-stage compare pipeline before the result is formed.
// Reset clears the box count and control state; the table needs no clearing.
// busy stays high from accept until the result strobe.
`timescale 1ns / 1ps

module box_table_collision_and_nearest import btcn_pkg::*; #(
   parameter int MAX_BOXES = BTCN_MAX_BOXES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   ctl_cmd_type      cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] addr;

   btcn_ctrl #(
      .MAX_BOXES (MAX_BOXES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_mode   (req_data.mode),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .addr       (addr)
   );

   btcn_dp #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .addr     (addr),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* design/btcn_dp.sv */
// Datapath: request register, box memory, scan pipeline and result register.
`timescale 1ns / 1ps
`include "box_table_collision_and_nearest_macros.svh"

module btcn_dp import btcn_pkg::*; #(
   parameter int MAX_BOXES = BTCN_MAX_BOXES,
   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   input  logic [IDX_W-1:0] addr,
   input  req_type       req_data,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   // Doubled center minus doubled query coordinate on one axis.
   function automatic logic signed [D_W-1:0] center_diff(
      input logic signed [15:0] corner,
      input logic signed [15:0] size,
      input logic signed [15:0] pt
   );
      logic signed [D_W-1:0] c2;
      c2 = (D_W'(corner) <<< 1) + D_W'(size);
      return c2 - (D_W'(pt) <<< 1);
   endfunction

   // Point lies within corner .. corner + size, ends included.
   function automatic logic in_span(
      input logic signed [15:0] corner,
      input logic signed [15:0] size,
      input logic signed [15:0] pt
   );
      logic signed [END_W-1:0] lo;
      logic signed [END_W-1:0] hi;
      logic signed [END_W-1:0] p;
      lo = END_W'(corner);
      hi = lo + END_W'(size);
      p  = END_W'(pt);
      return !(p < lo || p > hi);
   endfunction

   function automatic logic in_doorway(
      input logic signed [15:0] x,
      input logic signed [15:0] y
   );
      return (x > -16'sd512) && (x < 16'sd512) && (y > 16'sd0) && (y < 16'sd2048);
   endfunction

   // Fixed room rules for a move from point a to point b.
   function automatic logic room_ok(input req_type r);
      logic ok;
      logic xmid;
      logic ymid;
      logic zmid;
      logic door;
      ok   = 1'b1;
      xmid = (r.point_a_x > -16'(WALL)) && (r.point_a_x < 16'(WALL));
      ymid = (r.point_a_y > 16'sd0) && (r.point_a_y < 16'(WALL));
      zmid = (r.point_a_z > -16'(WALL)) && (r.point_a_z < 16'(WALL));
      door = in_doorway(r.point_a_x, r.point_a_y);
      if (xmid && ymid && zmid) begin
         if (!door && r.point_b_z <= -16'(WALL)) ok = 1'b0;
         if (r.point_b_z >= 16'(WALL)) ok = 1'b0;
         if (r.point_b_x <= -16'(WALL) || r.point_b_x >= 16'(WALL) ||
             r.point_b_y <= 16'sd0 || r.point_b_y >= 16'(WALL)) ok = 1'b0;
      end else begin
         if (xmid && ymid && r.point_a_z < -16'(WALL) && r.point_b_z >= -16'(WALL) && !door)
            ok = 1'b0;
         if (r.point_a_x < -16'(WALL) && ymid && zmid && r.point_b_x >= -16'(WALL))
            ok = 1'b0;
         if (r.point_a_x > 16'(WALL) && ymid && zmid && r.point_b_x <= 16'(WALL))
            ok = 1'b0;
         if (xmid && ymid && r.point_a_z > 16'(WALL) && r.point_b_z <= 16'(WALL))
            ok = 1'b0;
      end
      return ok;
   endfunction

   req_type req_ff;
   box_type mem [MAX_BOXES];
   box_type rd_ff;

   logic             s0_valid_ff;
   logic [IDX_W-1:0] s0_idx_ff;

   logic                  s1_valid_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   box_type               s1_box_ff;
   logic                  s1_inside_ff;
   logic signed [D_W-1:0] s1_d_ff [3];

   logic             s2_valid_ff;
   logic [IDX_W-1:0] s2_idx_ff;
   box_type          s2_box_ff;
   logic [SQ_W-1:0]  s2_sq_ff [3];

   logic              s3_valid_ff;
   logic [IDX_W-1:0]  s3_idx_ff;
   box_type           s3_box_ff;
   logic [DIST_W-1:0] s3_dist_ff;

   logic              hit_ff;
   logic              found_ff;
   logic [DIST_W-1:0] best_ff;
   logic [IDX_W-1:0]  pick_ff;
   box_type           pick_box_ff;

   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic signed [2*D_W-1:0] prod [3];
   logic [IDX_W+5:0]        pick_wide;
   logic                    take;

   // Capture the request on accept.
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // Box memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= '{corner_x: req_ff.point_a_x, corner_y: req_ff.point_a_y,
                        corner_z: req_ff.point_a_z, size_x: req_ff.point_b_x,
                        size_y: req_ff.point_b_y, size_z: req_ff.point_b_z};
      end
      if (cmd.rd_en) rd_ff <= mem[addr];
   end

   // Square each axis offset.
   always_comb begin
      for (int k = 0; k < 3; k++) prod[k] = s1_d_ff[k] * s1_d_ff[k];
   end

   assign take = s3_valid_ff && (!found_ff || (s3_dist_ff < best_ff));

   // Advance the scan pipeline.
   always_ff @(posedge clock) begin
      s0_idx_ff    <= addr;
      s1_idx_ff    <= s0_idx_ff;
      s1_box_ff    <= rd_ff;
      s1_d_ff[0]   <= center_diff(rd_ff.corner_x, rd_ff.size_x, req_ff.point_a_x);
      s1_d_ff[1]   <= center_diff(rd_ff.corner_y, rd_ff.size_y, req_ff.point_a_y);
      s1_d_ff[2]   <= center_diff(rd_ff.corner_z, rd_ff.size_z, req_ff.point_a_z);
      s1_inside_ff <= in_span(rd_ff.corner_x, rd_ff.size_x, req_ff.point_b_x) &&
                      in_span(rd_ff.corner_y, rd_ff.size_y, req_ff.point_b_y) &&
                      in_span(rd_ff.corner_z, rd_ff.size_z, req_ff.point_b_z);
      s2_idx_ff    <= s1_idx_ff;
      s2_box_ff    <= s1_box_ff;
      for (int k = 0; k < 3; k++) s2_sq_ff[k] <= prod[k][SQ_W-1:0];
      s3_idx_ff    <= s2_idx_ff;
      s3_box_ff    <= s2_box_ff;
      s3_dist_ff   <= DIST_W'(s2_sq_ff[0]) + DIST_W'(s2_sq_ff[1]) + DIST_W'(s2_sq_ff[2]);
      if (take) begin
         best_ff     <= s3_dist_ff;
         pick_ff     <= s3_idx_ff;
         pick_box_ff <= s3_box_ff;
      end
      rsp_ff <= rsp_in;
   end

   // Hold valid tags and accumulated flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         s0_valid_ff <= cmd.rd_en;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (cmd.load) begin
            hit_ff   <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            hit_ff   <= hit_ff | (s1_valid_ff & s1_inside_ff);
            found_ff <= found_ff | take;
         end
      end
   end

   assign pick_wide = {6'd0, pick_ff};

   // Form the result item for the current request.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.respond) begin
         rsp_in = '0;
         case (mode_type'(req_ff.mode))
            MODE_ADD:  rsp_in.table_full = cmd.refused;
            MODE_MOVE: rsp_in.move_allowed = room_ok(req_ff) && !hit_ff;
            MODE_NEAR: begin
               if (found_ff) begin
                  rsp_in.box_found        = 1'b1;
                  rsp_in.nearest_index    = pick_wide[5:0];
                  rsp_in.nearest_corner_x = pick_box_ff.corner_x;
                  rsp_in.nearest_corner_y = pick_box_ff.corner_y;
                  rsp_in.nearest_corner_z = pick_box_ff.corner_z;
                  rsp_in.nearest_size_x   = pick_box_ff.size_x;
                  rsp_in.nearest_size_y   = pick_box_ff.size_y;
                  rsp_in.nearest_size_z   = pick_box_ff.size_z;
               end
            end
            default: rsp_in = '0;
         endcase
      end
   end

   assign rsp_data         = rsp_ff;
   assign status.pipe_busy = s0_valid_ff | s1_valid_ff | s2_valid_ff | s3_valid_ff;

   // A result is formed only once the scan pipeline has drained.
   `BTCN_ASSERT_NOW(a_respond_drained, cmd.respond, !status.pipe_busy, "respond while pipe busy")
   // A new item never enters while boxes are still in flight.
   `BTCN_ASSERT_NOW(a_load_drained, cmd.load, !status.pipe_busy, "load while pipe busy")
   // A hit can only be recorded from a valid pipeline slot.
   `BTCN_ASSERT_NEXT(a_hit_source, !hit_ff && !s1_valid_ff, !hit_ff, "hit without valid box")

endmodule

/* design/btcn_ctrl.sv */
// Controller: sequences add, scan, drain and respond for each item.
`timescale 1ns / 1ps
`include "box_table_collision_and_nearest_macros.svh"

module btcn_ctrl import btcn_pkg::*; #(
   parameter int MAX_BOXES = BTCN_MAX_BOXES,
   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
   localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_mode,
   input  dp_status_type    status,
   output logic             busy,
   output logic             rsp_strobe,
   output ctl_cmd_type      cmd,
   output logic [IDX_W-1:0] addr
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] scan_ff;
   logic             refused_ff;
   logic             rsp_strobe_ff;

   logic accept;
   logic full;
   logic last;

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = (count_ff == CNT_W'(MAX_BOXES));
   assign last   = ((CNT_W'(scan_ff) + CNT_W'(1)) == count_ff);

   // Drive datapath commands from the state.
   assign cmd.load    = accept;
   assign cmd.wr_en   = (state_ff == ST_WRITE);
   assign cmd.rd_en   = (state_ff == ST_SCAN);
   assign cmd.respond = (state_ff == ST_FINISH);
   assign cmd.refused = refused_ff;
   assign addr        = (state_ff == ST_WRITE) ? count_ff[IDX_W-1:0] : scan_ff;

   // Hold state, box count and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         refused_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  refused_ff <= 1'b0;
                  scan_ff    <= '0;
                  case (mode_type'(req_mode))
                     MODE_ADD: begin
                        if (full) begin
                           refused_ff <= 1'b1;
                           state_ff   <= ST_FINISH;
                        end else begin
                           state_ff <= ST_WRITE;
                        end
                     end
                     MODE_MOVE, MODE_NEAR: begin
                        state_ff <= (count_ff == '0) ? ST_WAIT : ST_SCAN;
                     end
                     default: state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_WRITE: begin
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= ST_FINISH;
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + IDX_W'(1);
               if (last) state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (!status.pipe_busy) state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

   // Writes stay inside the table.
   `BTCN_ASSERT_NOW(a_write_room, cmd.wr_en, !full, "write into full table")
   // Reads only touch stored boxes.
   `BTCN_ASSERT_NOW(a_read_stored, cmd.rd_en, CNT_W'(addr) < count_ff, "read past box count")
   // An accepted item keeps the block busy until its result.
   `BTCN_ASSERT_NEXT(a_accept_busy, accept, busy, "not busy after accept")
   // A result comes out while the block is free again.
   `BTCN_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "result strobe while busy")

endmodule

/* sim/tb_box_table_collision_and_nearest.sv */
// Self-checking testbench: box table adds, move checks and nearest-box queries.
`timescale 1ns / 1ps

module tb_box_table_collision_and_nearest;
   import btcn_pkg::*;

   localparam int TABLE_DEPTH   = BTCN_MAX_BOXES;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam longint NEAR_LIMIT_SQ =
      longint'(2 * 10000 * Q_ONE) * longint'(2 * 10000 * Q_ONE);

   typedef struct {
      req_type req;
      int      idle_pct;
      bit      drain;
   } item_slot_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   item_slot_type item_queue [$];
   item_slot_type next_item;
   rsp_type       pending_answers [$];
   rsp_type       answer;
   int            items_total;
   int            items_taken;
   int            error_count;
   int            cycle_count;

   // shadow copy of the box table
   int shelf_corner [TABLE_DEPTH][3];
   int shelf_size [TABLE_DEPTH][3];
   int shelf_count;

   box_table_collision_and_nearest u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Room rules first, then any stored box that holds the target.
   function automatic bit target_free(req_type r);
      int  a [3];
      int  b [3];
      bit  ok;
      bit  xmid;
      bit  ymid;
      bit  zmid;
      bit  door;
      bit  hit;
      a[0] = r.point_a_x;
      a[1] = r.point_a_y;
      a[2] = r.point_a_z;
      b[0] = r.point_b_x;
      b[1] = r.point_b_y;
      b[2] = r.point_b_z;
      ok   = 1'b1;
      xmid = a[0] > -WALL && a[0] < WALL;
      ymid = a[1] > 0 && a[1] < WALL;
      zmid = a[2] > -WALL && a[2] < WALL;
      door = a[0] > -DOOR_HALF && a[0] < DOOR_HALF && a[1] > 0 && a[1] < DOOR_TOP;
      if (xmid && ymid && zmid) begin
         if (!door && b[2] <= -WALL) ok = 1'b0;
         if (b[2] >= WALL) ok = 1'b0;
         if (b[0] <= -WALL || b[0] >= WALL || b[1] <= 0 || b[1] >= WALL) ok = 1'b0;
      end else begin
         if (xmid && ymid && a[2] < -WALL && b[2] >= -WALL && !door) ok = 1'b0;
         if (a[0] < -WALL && ymid && zmid && b[0] >= -WALL) ok = 1'b0;
         if (a[0] > WALL && ymid && zmid && b[0] <= WALL) ok = 1'b0;
         if (xmid && ymid && a[2] > WALL && b[2] <= WALL) ok = 1'b0;
      end
      // box ends are exact here, so a negative size holds nothing
      for (int i = 0; i < shelf_count; i++) begin
         hit = 1'b1;
         for (int k = 0; k < 3; k++) begin
            if (b[k] < shelf_corner[i][k] || b[k] > shelf_corner[i][k] + shelf_size[i][k])
               hit = 1'b0;
         end
         if (hit) ok = 1'b0;
      end
      return ok;
   endfunction

   // Compute the result of one item and update the shadow table.
   function automatic rsp_type box_table_answer(req_type r);
      rsp_type ans;
      int      a [3];
      longint  best;
      longint  dist_sq;
      longint  d;
      int      pick;
      ans  = '0;
      a[0] = r.point_a_x;
      a[1] = r.point_a_y;
      a[2] = r.point_a_z;
      case (mode_type'(r.mode))
         MODE_ADD: begin
            if (shelf_count >= TABLE_DEPTH) begin
               ans.table_full = 1'b1;
            end else begin
               shelf_corner[shelf_count][0] = r.point_a_x;
               shelf_corner[shelf_count][1] = r.point_a_y;
               shelf_corner[shelf_count][2] = r.point_a_z;
               shelf_size[shelf_count][0]   = r.point_b_x;
               shelf_size[shelf_count][1]   = r.point_b_y;
               shelf_size[shelf_count][2]   = r.point_b_z;
               shelf_count++;
            end
         end
         MODE_MOVE: begin
            ans.move_allowed = target_free(r);
         end
         MODE_NEAR: begin
            // compare doubled-center squared distances, first box wins a tie
            best = NEAR_LIMIT_SQ;
            pick = -1;
            for (int i = 0; i < shelf_count; i++) begin
               dist_sq = 0;
               for (int k = 0; k < 3; k++) begin
                  d = 2 * longint'(shelf_corner[i][k]) + longint'(shelf_size[i][k])
                      - 2 * longint'(a[k]);
                  dist_sq += d * d;
               end
               if (dist_sq < best) begin
                  best = dist_sq;
                  pick = i;
               end
            end
            if (pick >= 0) begin
               ans.box_found        = 1'b1;
               ans.nearest_index    = 6'(pick);
               ans.nearest_corner_x = 16'(shelf_corner[pick][0]);
               ans.nearest_corner_y = 16'(shelf_corner[pick][1]);
               ans.nearest_corner_z = 16'(shelf_corner[pick][2]);
               ans.nearest_size_x   = 16'(shelf_size[pick][0]);
               ans.nearest_size_y   = 16'(shelf_size[pick][1]);
               ans.nearest_size_z   = 16'(shelf_size[pick][2]);
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic int field_mismatch(string name, logic signed [16:0] exp_val,
                                         logic signed [16:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   function automatic req_type make_req(mode_type m, int ax, int ay, int az,
                                        int bx, int by, int bz);
      req_type r;
      r.mode      = m;
      r.point_a_x = 16'(ax);
      r.point_a_y = 16'(ay);
      r.point_a_z = 16'(az);
      r.point_b_x = 16'(bx);
      r.point_b_y = 16'(by);
      r.point_b_z = 16'(bz);
      return r;
   endfunction

   function automatic void queue_item(req_type r, int pct, bit drain);
      item_slot_type slot;
      slot.req      = r;
      slot.idle_pct = pct;
      slot.drain    = drain;
      item_queue.insert(item_queue.size(), slot);
   endfunction

   // Mostly room-scale values, often on a wall or doorway edge, some raw.
   function automatic int room_coord();
      int                 roll;
      int                 mark;
      logic signed [15:0] raw;
      roll = $urandom_range(0, 99);
      if (roll < 45) return int'($urandom_range(0, 24 * Q_ONE)) - 12 * Q_ONE;
      if (roll < 75) begin
         case ($urandom_range(0, 5))
            0: mark = -WALL;
            1: mark = WALL;
            2: mark = 0;
            3: mark = -DOOR_HALF;
            4: mark = DOOR_HALF;
            default: mark = DOOR_TOP;
         endcase
         return mark + int'($urandom_range(0, 2)) - 1;
      end
      raw = 16'($urandom);
      return raw;
   endfunction

   function automatic int box_extent();
      int                 roll;
      logic signed [15:0] raw;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 4 * Q_ONE);
      if (roll < 85) return -int'($urandom_range(1, Q_ONE));
      raw = 16'($urandom);
      return raw;
   endfunction

   // Offset from a box corner, inside it unless extent < 0, often on the far edge.
   function automatic int inside_offset(int extent);
      if (extent < 0) return $urandom_range(0, 2 * Q_ONE);
      if ($urandom_range(0, 2) == 0) return extent;
      return $urandom_range(0, extent);
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Drive items from the queue; hold each one until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            pending_answers.insert(pending_answers.size(), box_table_answer(req_data));
            items_taken++;
         end
         if (!start || !busy) begin
            if (item_queue.size() != 0
                && !(item_queue[0].drain && pending_answers.size() != 0)
                && $urandom_range(0, 99) >= item_queue[0].idle_pct) begin
               next_item = item_queue.pop_front();
               req_data <= next_item.req;
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Check each result against the oldest outstanding answer.
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            $error("result strobe with no item outstanding");
            error_count++;
         end else begin
            answer = pending_answers.pop_front();
            error_count += field_mismatch("move_allowed", answer.move_allowed,
                                          rsp_data.move_allowed);
            error_count += field_mismatch("table_full", answer.table_full,
                                          rsp_data.table_full);
            error_count += field_mismatch("box_found", answer.box_found,
                                          rsp_data.box_found);
            error_count += field_mismatch("nearest_index", answer.nearest_index,
                                          rsp_data.nearest_index);
            error_count += field_mismatch("nearest_corner_x", answer.nearest_corner_x,
                                          rsp_data.nearest_corner_x);
            error_count += field_mismatch("nearest_corner_y", answer.nearest_corner_y,
                                          rsp_data.nearest_corner_y);
            error_count += field_mismatch("nearest_corner_z", answer.nearest_corner_z,
                                          rsp_data.nearest_corner_z);
            error_count += field_mismatch("nearest_size_x", answer.nearest_size_x,
                                          rsp_data.nearest_size_x);
            error_count += field_mismatch("nearest_size_y", answer.nearest_size_y,
                                          rsp_data.nearest_size_y);
            error_count += field_mismatch("nearest_size_z", answer.nearest_size_z,
                                          rsp_data.nearest_size_z);
         end
      end
   end

   // Build the item list, run reset, then wait for the last result.
   initial begin
      req_type   sel;
      req_type   stored_adds [$];
      int        roll;
      int        pct;
      int        pa [3];
      int        pb [3];
      mode_type  m;

      reset = 1'b1;

      // empty table, unused mode, extreme boxes
      queue_item(make_req(MODE_NEAR, 0, 0, 0, 0, 0, 0), 0, 1'b1);
      queue_item(make_req(MODE_MOVE, 0, 256, 0, 256, 512, 256), 0, 1'b0);
      queue_item(make_req(MODE_NONE, -1, -1, -1, -1, -1, -1), 0, 1'b0);
      queue_item(make_req(MODE_ADD, 32767, 32767, 32767, 32767, 32767, 32767), 0, 1'b0);
      queue_item(make_req(MODE_ADD, -32768, -32768, -32768, -32768, -32768, -32768),
                 0, 1'b0);
      queue_item(make_req(MODE_ADD, -256, 256, -256, 512, 512, 512), 0, 1'b0);
      // two identical boxes for the tie
      queue_item(make_req(MODE_ADD, 1024, 1024, 1024, 256, 256, 256), 0, 1'b0);
      queue_item(make_req(MODE_ADD, 1024, 1024, 1024, 256, 256, 256), 0, 1'b0);
      // inclusive box bounds
      queue_item(make_req(MODE_MOVE, 2048, 2048, 2048, -256, 256, -256), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 2048, 2048, 2048, 256, 768, 256), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 2048, 2048, 2048, 257, 768, 256), 0, 1'b0);
      // room walls and the doorway
      queue_item(make_req(MODE_MOVE, 2048, 2048, 2048, 2048, 2048, -WALL), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 0, 1024, 0, 0, 1024, -WALL - 256), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 0, 0, 0, 0, 0, 0), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 2048, 2048, 2048, WALL, 2048, 0), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 2048, 2048, 2048, 0, WALL, 0), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 2048, 2048, -WALL - 256, 2048, 2048, -WALL), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 0, 1024, -WALL - 256, 0, 1024, 0), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, -WALL - 256, 2048, 0, -WALL, 2048, 0), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, WALL + 256, 2048, 0, WALL, 2048, 0), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 0, 2048, WALL + 256, 0, 2048, WALL), 0, 1'b0);
      queue_item(make_req(MODE_MOVE, 0, 256, 0, 32767, 32767, 32767), 0, 1'b0);
      queue_item(make_req(MODE_NEAR, 1152, 1152, 1152, 0, 0, 0), 0, 1'b0);
      queue_item(make_req(MODE_NEAR, -32768, -32768, -32768, 0, 0, 0), 0, 1'b0);
      queue_item(make_req(MODE_NEAR, 32767, 32767, 32767, 0, 0, 0), 0, 1'b0);

      // random items in idle phases; the table fills and then refuses adds
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case (i / PHASE_ITEMS)
            1: pct = 49;
            3: pct = 13;
            default: pct = 0;
         endcase
         for (int k = 0; k < 3; k++) pa[k] = room_coord();
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            m = MODE_ADD;
            for (int k = 0; k < 3; k++) pb[k] = box_extent();
         end else if (roll < 60) begin
            m = MODE_MOVE;
            if (stored_adds.size() != 0 && $urandom_range(0, 99) < 30) begin
               sel   = stored_adds[$urandom_range(0, stored_adds.size() - 1)];
               pb[0] = sel.point_a_x + inside_offset(sel.point_b_x);
               pb[1] = sel.point_a_y + inside_offset(sel.point_b_y);
               pb[2] = sel.point_a_z + inside_offset(sel.point_b_z);
            end else if ($urandom_range(0, 1) == 0) begin
               for (int k = 0; k < 3; k++)
                  pb[k] = pa[k] + int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
            end else begin
               for (int k = 0; k < 3; k++) pb[k] = room_coord();
            end
         end else if (roll < 95) begin
            m = MODE_NEAR;
            for (int k = 0; k < 3; k++) pb[k] = int'($urandom_range(0, 65535));
         end else begin
            m = MODE_NONE;
            for (int k = 0; k < 3; k++) pb[k] = int'($urandom_range(0, 65535));
         end
         sel = make_req(m, pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
         if (m == MODE_ADD && stored_adds.size() < TABLE_DEPTH)
            stored_adds.insert(stored_adds.size(), sel);
         queue_item(sel, pct, i % PHASE_ITEMS == 0);
      end
      items_total = item_queue.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for every item to be taken and every result to arrive
      while (items_taken < items_total) @(negedge clock);
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
